>>> hw/rtl/olc_pkg.sv
// Shared types and constants for the odor level classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package olc_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int SUM_BITS    = 16;
    localparam int CFG_BITS    = 16;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_THRESHOLD_MID  = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD_HIGH = 2'd1;
    localparam logic [1:0] CFG_WINDOW_SAMPLES = 2'd2;
    localparam logic [1:0] CFG_SETTLE_CALLS   = 2'd3;

    // power modes
    localparam logic [2:0] MODE_MEASURE = 3'd1;
    localparam logic [2:0] MODE_LOW     = 3'd2;
    localparam logic [2:0] MODE_MID     = 3'd3;
    localparam logic [2:0] MODE_HIGH    = 3'd4;

    // odor levels
    localparam logic [1:0] LEVEL_LOW  = 2'd0;
    localparam logic [1:0] LEVEL_MID  = 2'd1;
    localparam logic [1:0] LEVEL_HIGH = 2'd2;

    // LED vector bits: 0 low, 1 mid, 2 high; flag vector bits: 0 flag_a, 1 flag_b
    localparam logic [2:0] LED_LOW  = 3'b001;
    localparam logic [2:0] LED_MID  = 3'b010;
    localparam logic [2:0] LED_HIGH = 3'b100;

    localparam logic [1:0] FLAGS_LOW  = 2'b01;
    localparam logic [1:0] FLAGS_MID  = 2'b11;
    localparam logic [1:0] FLAGS_HIGH = 2'b10;

    typedef struct packed {
        logic [15:0] threshold_mid;
        logic [15:0] threshold_high;
        logic [7:0]  window_samples;
        logic [15:0] settle_calls;
    } cfg_t;

    typedef struct packed {
        logic [2:0]             power_mode;
        logic                   sample_valid;
        logic [SAMPLE_BITS-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [2:0] leds;
        logic [1:0] flags;
        logic       aux;
        logic [1:0] level;
    } result_t;

    // LED for a level code; unused codes light nothing
    function automatic logic [2:0] level_led(input logic [1:0] lvl);
        logic [2:0] led;
        case (lvl)
            LEVEL_LOW:  led = LED_LOW;
            LEVEL_MID:  led = LED_MID;
            LEVEL_HIGH: led = LED_HIGH;
            default:    led = 3'b000;
        endcase
        return led;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/olc_cfg_regs.sv
// Configuration register file of the odor level classifier.
// Depends on olc_pkg for register indexes and the cfg_t layout.
`default_nettype none

module olc_cfg_regs
    import olc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [CFG_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_mid  <= 16'd37064;
            cfg_reg.threshold_high <= 16'd43566;
            cfg_reg.window_samples <= 8'd255;
            cfg_reg.settle_calls   <= 16'd2500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD_MID:  cfg_reg.threshold_mid  <= cfg_data;
                CFG_THRESHOLD_HIGH: cfg_reg.threshold_high <= cfg_data;
                CFG_WINDOW_SAMPLES: cfg_reg.window_samples <= cfg_data[7:0];
                CFG_SETTLE_CALLS:   cfg_reg.settle_calls   <= cfg_data;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/olc_core.sv
// Classifier state and its single-pass update for one request.
// Depends on olc_pkg; fed by the input register of the top level.
`default_nettype none

module olc_core
    import olc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire item_t item,
    input  wire logic  advance,
    output result_t    result_next
);

    logic [2:0]          accepted_mode_reg, accepted_mode_next;
    logic [15:0]         settle_counter_reg, settle_counter_next;
    logic [SUM_BITS-1:0] window_sum_reg, window_sum_next;
    logic [7:0]          window_count_reg, window_count_next;
    logic [1:0]          current_level_reg, current_level_next;
    logic [1:0]          shown_level_reg, shown_level_next;
    logic [2:0]          led_reg, led_next;
    logic [1:0]          flag_reg, flag_next;
    logic                aux_reg, aux_next;

    logic [15:0]         settle_inc;
    logic [SUM_BITS:0]   sum_wide;
    logic [SUM_BITS-1:0] sum_sat;
    logic [7:0]          count_inc;
    logic [1:0]          new_level;

    assign settle_inc = settle_counter_reg + 16'd1;
    assign sum_wide   = {1'b0, window_sum_reg} + (SUM_BITS + 1)'(item.sample);
    assign sum_sat    = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
    assign count_inc  = window_count_reg + 8'd1;

    always_comb
    begin
        if (sum_sat > cfg.threshold_high)
            new_level = LEVEL_HIGH;
        else if (sum_sat > cfg.threshold_mid)
            new_level = LEVEL_MID;
        else
            new_level = LEVEL_LOW;
    end

    always_comb
    begin
        accepted_mode_next  = accepted_mode_reg;
        settle_counter_next = settle_counter_reg;
        window_sum_next     = window_sum_reg;
        window_count_next   = window_count_reg;
        current_level_next  = current_level_reg;
        shown_level_next    = shown_level_reg;
        led_next            = led_reg;
        flag_next           = flag_reg;
        aux_next            = aux_reg;

        // mode change: blank LEDs and count toward takeover
        if (item.power_mode != accepted_mode_reg)
        begin
            led_next            = 3'b000;
            settle_counter_next = settle_inc;
            if (settle_inc >= cfg.settle_calls)
            begin
                settle_counter_next = 16'd0;
                accepted_mode_next  = item.power_mode;
                if (item.power_mode == MODE_MEASURE)
                begin
                    led_next = level_led(current_level_reg);
                end
                else
                begin
                    case (item.power_mode)
                        MODE_LOW:  led_next = LED_LOW;
                        MODE_MID:  led_next = LED_MID;
                        MODE_HIGH: led_next = LED_HIGH;
                        default:   led_next = 3'b000;
                    endcase
                    aux_next  = 1'b1;
                    flag_next = 2'b00;
                end
            end
        end

        // accumulate and classify at the end of a window
        if (item.power_mode == MODE_MEASURE && item.sample_valid)
        begin
            window_sum_next   = sum_sat;
            window_count_next = count_inc;
            if (count_inc >= cfg.window_samples)
            begin
                window_count_next  = 8'd0;
                window_sum_next    = '0;
                current_level_next = new_level;
                if (shown_level_reg != new_level)
                begin
                    shown_level_next = new_level;
                    led_next         = level_led(new_level);
                    case (new_level)
                        LEVEL_LOW:  flag_next = FLAGS_LOW;
                        LEVEL_MID:  flag_next = FLAGS_MID;
                        default:    flag_next = FLAGS_HIGH;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_mode_reg  <= 3'd0;
            settle_counter_reg <= 16'd0;
            window_sum_reg     <= '0;
            window_count_reg   <= 8'd0;
            current_level_reg  <= LEVEL_LOW;
            shown_level_reg    <= LEVEL_LOW;
            led_reg            <= 3'b000;
            flag_reg           <= 2'b00;
            aux_reg            <= 1'b0;
        end
        else if (advance)
        begin
            accepted_mode_reg  <= accepted_mode_next;
            settle_counter_reg <= settle_counter_next;
            window_sum_reg     <= window_sum_next;
            window_count_reg   <= window_count_next;
            current_level_reg  <= current_level_next;
            shown_level_reg    <= shown_level_next;
            led_reg            <= led_next;
            flag_reg           <= flag_next;
            aux_reg            <= aux_next;
        end
    end

    assign result_next.leds  = led_next;
    assign result_next.flags = flag_next;
    assign result_next.aux   = aux_next;
    assign result_next.level = current_level_next;

endmodule

`default_nettype wire

>>> hw/rtl/odor_level_classifier.sv
// Top level of the odor level classifier: input register, core, result register.
// Depends on olc_pkg, olc_cfg_regs and olc_core.
`default_nettype none

// Each request sits in the input register; once the result register is free,
// the core updates its state and the result register in a single pass.
// Throughput is one request per clock while out_ready stays high; a stalled
// result holds the input register and backpressures in_ready. Configuration
// writes take effect on the next cycle and should be made while no request is
// in flight.

module odor_level_classifier
    import olc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [CFG_BITS-1:0]    cfg_data,

    input  wire logic                   in_valid,
    output      logic                   in_ready,
    input  wire logic [2:0]             power_mode,
    input  wire logic                   sample_valid,
    input  wire logic [SAMPLE_BITS-1:0] sample,

    output      logic                   out_valid,
    input  wire logic                   out_ready,
    output      logic                   led_low,
    output      logic                   led_mid,
    output      logic                   led_high,
    output      logic                   flag_a,
    output      logic                   flag_b,
    output      logic                   aux_enable,
    output      logic [1:0]             level
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;
    logic    advance;

    olc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // move the held request into the result register when it is free
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.power_mode   <= power_mode;
            item_reg.sample_valid <= sample_valid;
            item_reg.sample       <= sample;
        end
    end

    olc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item        (item_reg),
        .advance     (advance),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign led_low    = result_reg.leds[0];
    assign led_mid    = result_reg.leds[1];
    assign led_high   = result_reg.leds[2];
    assign flag_a     = result_reg.flags[0];
    assign flag_b     = result_reg.flags[1];
    assign aux_enable = result_reg.aux;
    assign level      = result_reg.level;

endmodule

`default_nettype wire
